FILE: hdl/rmpc_pkg.sv
// Shared types and constants for the RGBA mip chain pixel converter.
package rmpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT  = 3'd3;

  localparam logic [3:0] FMT_ARGB8    = 4'd0;
  localparam logic [3:0] FMT_XRGB8    = 4'd1;
  localparam logic [3:0] FMT_ARGB4    = 4'd2;
  localparam logic [3:0] FMT_XRGB4    = 4'd3;
  localparam logic [3:0] FMT_RGB565   = 4'd4;
  localparam logic [3:0] FMT_ARGB1555 = 4'd5;
  localparam logic [3:0] FMT_XRGB1555 = 4'd6;
  localparam logic [3:0] FMT_AL88     = 4'd7;
  localparam logic [3:0] FMT_L8       = 4'd8;
  localparam logic [3:0] FMT_A8       = 4'd9;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;
    logic [3:0]  level;
    logic [13:0] column;
    logic [13:0] row;
    logic        level_end;
    logic        chain_end;
    logic        format_error;
  } out_t;

  typedef struct packed {
    logic [3:0]  fmt;
    logic [3:0]  level;
    logic [13:0] column;
    logic [13:0] row;
    logic        level_end;
    logic        chain_end;
    logic        cfg_bad;
    logic        chain_done;
  } status_t;

endpackage

FILE: hdl/rgba_mip_chain_pixel_converter.sv
// Top level: input register, conversion and position logic, result register.
// out_valid rises once the item moves from the input register into the result register.
// Throughput: one item per cycle unless out_ready stalls, via a single conversion pass.
// Items after the chain end are consumed and give no result.
// Reset (synchronous, active high) clears both pipeline registers and restarts the chain
// with format 0, 1x1 base and a level limit of 1.
module rgba_mip_chain_pixel_converter
  import rmpc_pkg::*;
#(
  parameter int MAX_DIM = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        s1_valid;
  in_t         s1_pix;
  status_t     st;
  logic [31:0] conv_bytes;
  logic [2:0]  conv_count;
  logic        emit;
  logic        s1_go;
  logic        step;
  out_t        result;

  rmpc_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (step),
    .status   (st)
  );

  rmpc_convert u_convert (
    .fmt  (st.fmt),
    .pix  (s1_pix),
    .bytes(conv_bytes),
    .count(conv_count)
  );

  assign emit     = s1_valid && (st.cfg_bad || !st.chain_done);
  assign s1_go    = s1_valid && (!out_valid || out_ready || !emit);
  assign in_ready = !s1_valid || s1_go;
  assign step     = s1_go && emit && !st.cfg_bad;

  always_comb begin
    if (st.cfg_bad) begin
      result              = '0;
      result.format_error = 1'b1;
    end else begin
      result.pixel_bytes  = conv_bytes;
      result.byte_count   = conv_count;
      result.level        = st.level;
      result.column       = st.column;
      result.row          = st.row;
      result.level_end    = st.level_end;
      result.chain_end    = st.chain_end;
      result.format_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_pix <= in_item;
    end
    if (s1_go && emit) begin
      out_item <= result;
    end
  end

  // chain is closed by its last item
  a_chain_close: assert property (@(posedge clk) disable iff (rst)
    (step && st.chain_end && !cfg_we) |=> st.chain_done)
    else $error("chain not closed after last item");

  // no item advances the position once the chain is done
  a_no_step_done: assert property (@(posedge clk) disable iff (rst)
    step |-> !st.chain_done)
    else $error("position advanced after chain end");

  // level end moves to the start of the next level
  a_next_level: assert property (@(posedge clk) disable iff (rst)
    (step && st.level_end && !st.chain_end && !cfg_we) |=>
      (st.column == 14'd0 && st.row == 14'd0 && st.level == $past(st.level) + 4'd1))
    else $error("bad level advance");

  // error results carry no bytes
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.format_error) |-> (out_item.byte_count == 3'd0 &&
      out_item.pixel_bytes == 32'd0 && !out_item.chain_end))
    else $error("error item carries data");

endmodule

FILE: hdl/rmpc_convert.sv
// Per-pixel conversion of RGBA8 to the selected packed byte format.
module rmpc_convert
  import rmpc_pkg::*;
(
  input  logic [3:0]  fmt,
  input  in_t         pix,
  output logic [31:0] bytes,
  output logic [2:0]  count
);

  logic [7:0] r4;
  logic [7:0] g4;
  logic [7:0] b4;
  logic [7:0] a4;
  logic       abit;

  assign r4   = {pix.red[7:4], pix.red[7:4]};
  assign g4   = {pix.green[7:4], pix.green[7:4]};
  assign b4   = {pix.blue[7:4], pix.blue[7:4]};
  assign a4   = {pix.alpha[7:4], pix.alpha[7:4]};
  assign abit = (fmt == FMT_XRGB1555) || pix.alpha[7];

  always_comb begin
    unique case (fmt)
      FMT_ARGB8: begin
        bytes = {pix.alpha, pix.red, pix.green, pix.blue};
        count = 3'd4;
      end
      FMT_XRGB8: begin
        bytes = {8'hFF, pix.red, pix.green, pix.blue};
        count = 3'd4;
      end
      FMT_ARGB4: begin
        bytes = {a4, r4, g4, b4};
        count = 3'd4;
      end
      FMT_XRGB4: begin
        bytes = {8'hFF, r4, g4, b4};
        count = 3'd4;
      end
      FMT_RGB565: begin
        bytes = {16'd0, pix.red[7:3], pix.green[7:2], pix.blue[7:3]};
        count = 3'd2;
      end
      FMT_ARGB1555, FMT_XRGB1555: begin
        bytes = {16'd0, abit, pix.red[7:3], pix.green[7:3], pix.blue[7:3]};
        count = 3'd2;
      end
      FMT_AL88: begin
        bytes = {16'd0, pix.alpha, pix.red};
        count = 3'd2;
      end
      FMT_L8: begin
        bytes = {24'd0, pix.red};
        count = 3'd1;
      end
      FMT_A8: begin
        bytes = {24'd0, pix.alpha};
        count = 3'd1;
      end
      default: begin
        bytes = 32'd0;
        count = 3'd0;
      end
    endcase
  end

endmodule

FILE: hdl/rmpc_ctrl.sv
// Configuration registers and mip chain position tracking.
module rmpc_ctrl
  import rmpc_pkg::*;
#(
  parameter int MAX_DIM = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output status_t               status
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [3:0]            pixel_format;
  logic [14:0]           base_width;
  logic [14:0]           base_height;
  logic [3:0]            level_limit;
  logic [DIM_W-1:0]      cur_column;
  logic [DIM_W-1:0]      cur_row;
  logic [DIM_W-1:0]      level_width;
  logic [DIM_W-1:0]      level_height;
  logic [3:0]            cur_level;
  logic                  chain_done;

  logic                  col_last;
  logic                  row_last;
  logic                  lend;
  logic                  cend;
  logic                  cfg_hit;
  logic [14:0]           bw_new;
  logic [14:0]           bh_new;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [14:0] v);
    if (32'(v) > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v);
  endfunction

  assign col_last = ((DIM_W+1)'(cur_column) + (DIM_W+1)'(1)) >= (DIM_W+1)'(level_width);
  assign row_last = ((DIM_W+1)'(cur_row) + (DIM_W+1)'(1)) >= (DIM_W+1)'(level_height);
  assign lend     = col_last && row_last;
  assign cend     = lend && (((level_width >> 1) == '0) || ((level_height >> 1) == '0) ||
                             ((5'(cur_level) + 5'd1) >= 5'(level_limit)));

  assign cfg_hit = cfg_we && (cfg_index <= REG_LEVEL_LIMIT);
  assign bw_new  = (cfg_index == REG_BASE_WIDTH) ? cfg_data : base_width;
  assign bh_new  = (cfg_index == REG_BASE_HEIGHT) ? cfg_data : base_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_ARGB8;
      base_width   <= 15'd1;
      base_height  <= 15'd1;
      level_limit  <= 4'd1;
      cur_column   <= '0;
      cur_row      <= '0;
      cur_level    <= '0;
      chain_done   <= 1'b0;
      level_width  <= DIM_W'(1);
      level_height <= DIM_W'(1);
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[3:0];
        REG_BASE_WIDTH:   base_width   <= cfg_data;
        REG_BASE_HEIGHT:  base_height  <= cfg_data;
        default:          level_limit  <= cfg_data[3:0];
      endcase
      cur_column   <= '0;
      cur_row      <= '0;
      cur_level    <= '0;
      chain_done   <= 1'b0;
      level_width  <= clamp_dim(bw_new);
      level_height <= clamp_dim(bh_new);
    end else if (step) begin
      priority if (cend) begin
        chain_done <= 1'b1;
      end else if (lend) begin
        cur_column   <= '0;
        cur_row      <= '0;
        cur_level    <= cur_level + 4'd1;
        level_width  <= level_width >> 1;
        level_height <= level_height >> 1;
      end else if (col_last) begin
        cur_column <= '0;
        cur_row    <= cur_row + DIM_W'(1);
      end else begin
        cur_column <= cur_column + DIM_W'(1);
      end
    end
  end

  assign status.fmt        = pixel_format;
  assign status.level      = cur_level;
  assign status.column     = 14'(cur_column);
  assign status.row        = 14'(cur_row);
  assign status.level_end  = lend;
  assign status.chain_end  = cend;
  assign status.cfg_bad    = (pixel_format > FMT_A8) || (base_width == '0) ||
                             (base_height == '0) || (level_limit == '0);
  assign status.chain_done = chain_done;

endmodule

FILE: tb/tb.sv
// Testbench for the RGBA mip chain pixel converter: random chains checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import rmpc_pkg::*;

  localparam int MAX_DIM     = 16384;
  localparam int STALL_LIMIT = 2000;

  class mip_pixel_scoreboard;
    logic [3:0]  fmt;
    logic [14:0] base_w;
    logic [14:0] base_h;
    logic [3:0]  lim;
    int unsigned col, row, lvl, lvl_w, lvl_h;
    bit          done;
    out_t        pending_pixels[$];
    int          errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      fmt    = FMT_ARGB8;
      base_w = 1;
      base_h = 1;
      lim    = 1;
      restart_chain();
    endfunction

    function void restart_chain();
      col   = 0;
      row   = 0;
      lvl   = 0;
      done  = 0;
      lvl_w = (base_w > MAX_DIM) ? MAX_DIM : base_w;
      lvl_h = (base_h > MAX_DIM) ? MAX_DIM : base_h;
    endfunction

    function bit config_bad();
      return fmt > FMT_A8 || base_w == 0 || base_h == 0 || lim == 0;
    endfunction

    // indexes past the register list are dropped without a restart
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIXEL_FORMAT: fmt = data[3:0];
        REG_BASE_WIDTH:   base_w = data;
        REG_BASE_HEIGHT:  base_h = data;
        REG_LEVEL_LIMIT:  lim = data[3:0];
        default: return;
      endcase
      restart_chain();
    endfunction

    function logic [7:0] widen4(logic [7:0] c);
      return {c[7:4], c[7:4]};
    endfunction

    function out_t convert_pixel(in_t p);
      out_t o = '0;
      case (fmt)
        FMT_ARGB8: begin
          o.pixel_bytes = {p.alpha, p.red, p.green, p.blue};
          o.byte_count  = 4;
        end
        FMT_XRGB8: begin
          o.pixel_bytes = {8'hFF, p.red, p.green, p.blue};
          o.byte_count  = 4;
        end
        FMT_ARGB4: begin
          o.pixel_bytes = {widen4(p.alpha), widen4(p.red), widen4(p.green), widen4(p.blue)};
          o.byte_count  = 4;
        end
        FMT_XRGB4: begin
          o.pixel_bytes = {8'hFF, widen4(p.red), widen4(p.green), widen4(p.blue)};
          o.byte_count  = 4;
        end
        FMT_RGB565: begin
          o.pixel_bytes = {16'h0, p.red[7:3], p.green[7:2], p.blue[7:3]};
          o.byte_count  = 2;
        end
        FMT_ARGB1555, FMT_XRGB1555: begin
          o.pixel_bytes = {16'h0, (fmt == FMT_XRGB1555) || p.alpha[7],
                           p.red[7:3], p.green[7:3], p.blue[7:3]};
          o.byte_count  = 2;
        end
        FMT_AL88: begin
          o.pixel_bytes = {16'h0, p.alpha, p.red};
          o.byte_count  = 2;
        end
        FMT_L8: begin
          o.pixel_bytes = {24'h0, p.red};
          o.byte_count  = 1;
        end
        FMT_A8: begin
          o.pixel_bytes = {24'h0, p.alpha};
          o.byte_count  = 1;
        end
        default: o = '0;
      endcase
      return o;
    endfunction

    // returns 1 when the item is expected to give a result
    function bit note_pixel(in_t p);
      out_t o = '0;
      bit   lend, cend;
      if (config_bad()) begin
        o.format_error = 1'b1;
        pending_pixels.insert(pending_pixels.size(), o);
        return 1;
      end
      if (done) return 0;
      o    = convert_pixel(p);
      lend = (col + 1 >= lvl_w) && (row + 1 >= lvl_h);
      cend = lend && ((lvl_w >> 1) == 0 || (lvl_h >> 1) == 0 || lvl + 1 >= lim);
      o.level     = 4'(lvl);
      o.column    = 14'(col);
      o.row       = 14'(row);
      o.level_end = lend;
      o.chain_end = cend;
      pending_pixels.insert(pending_pixels.size(), o);
      if (cend) begin
        done = 1;
      end else if (lend) begin
        col   = 0;
        row   = 0;
        lvl   = (lvl + 1) & 4'hF;
        lvl_w = lvl_w >> 1;
        lvl_h = lvl_h >> 1;
      end else if (col + 1 >= lvl_w) begin
        col = 0;
        row = row + 1;
      end else begin
        col = col + 1;
      end
      return 1;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(out_t got);
      out_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with no item pending: %p", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      cmp_field("pixel_bytes", want.pixel_bytes, got.pixel_bytes);
      cmp_field("byte_count", want.byte_count, got.byte_count);
      cmp_field("level", want.level, got.level);
      cmp_field("column", want.column, got.column);
      cmp_field("row", want.row, got.row);
      cmp_field("level_end", want.level_end, got.level_end);
      cmp_field("chain_end", want.chain_end, got.chain_end);
      cmp_field("format_error", want.format_error, got.format_error);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mip_pixel_scoreboard sb;
  int send_idle = 8;
  int recv_idle = 60;
  int pixels_fed = 0;
  int stall_cycles = 0;

  rgba_mip_chain_pixel_converter #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_pixel(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function in_t random_pixel();
    in_t p;
    p.red   = pick_byte();
    p.green = pick_byte();
    p.blue  = pick_byte();
    p.alpha = pick_byte();
    return p;
  endfunction

  function int chain_len(int w, int h, int lim);
    int n = 0;
    if (w > MAX_DIM) w = MAX_DIM;
    if (h > MAX_DIM) h = MAX_DIM;
    for (int l = 0; l < lim; l++) begin
      n += w * h;
      if (w / 2 == 0 || h / 2 == 0) break;
      w = w / 2;
      h = h / 2;
    end
    return n;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(in_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= p;
    do @(posedge clk); while (!in_ready);
    if (sb.note_pixel(p)) pixels_fed++;
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [3:0] f, logic [14:0] w, logic [14:0] h, logic [3:0] lim);
    quiesce();
    set_reg(REG_PIXEL_FORMAT, {11'($urandom), f});
    set_reg(REG_BASE_WIDTH, w);
    set_reg(REG_BASE_HEIGHT, h);
    set_reg(REG_LEVEL_LIMIT, {11'($urandom), lim});
    cfg_we <= 1'b0;
  endtask

  task automatic run_chain(logic [3:0] f, logic [14:0] w, logic [14:0] h, logic [3:0] lim,
                           int cap);
    int total, extra, junk_at;
    configure(f, w, h, lim);
    extra = 0;
    if (sb.config_bad()) begin
      total = $urandom_range(1, 6);
    end else begin
      total = chain_len(w, h, lim);
      if (total > cap || $urandom_range(5) == 0)
        total = $urandom_range(1, total > cap ? cap : total);
      else extra = $urandom_range(0, 2);
    end
    junk_at = ($urandom_range(3) == 0) ? $urandom_range(1, total) : -1;
    for (int i = 0; i < total + extra; i++) begin
      // write past the register list mid-chain: must leave the position alone
      if (i == junk_at) begin
        quiesce();
        set_reg(CFG_IDX_W'($urandom_range(4, 7)), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
      end
      send_pixel(random_pixel());
    end
  endtask

  task automatic random_chain();
    logic [3:0]  f, lim;
    logic [14:0] dim[2];
    f = ($urandom_range(11) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(19))
        0: dim[k] = 0;
        1: dim[k] = 15'($urandom_range(16385, 32767));
        2: dim[k] = 15'($urandom_range(17, 300));
        default: dim[k] = 15'($urandom_range(1, 16));
      endcase
    end
    lim = ($urandom_range(14) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    run_chain(f, dim[0], dim[1], lim, 200);
  endtask

  initial begin
    in_t bright, dark;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config is a 1x1 chain; the second item falls past its end
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    bright.red   = 8'hFF;
    bright.green = 8'hFF;
    bright.blue  = 8'hFF;
    bright.alpha = 8'h80;
    dark.red     = 8'h00;
    dark.green   = 8'h00;
    dark.blue    = 8'h00;
    dark.alpha   = 8'h7F;
    for (int f = FMT_ARGB8; f <= FMT_A8; f++) begin
      configure(4'(f), 2, 1, 15);
      send_pixel(bright);
      send_pixel(dark);
    end
    configure(4'd15, 2, 1, 1);
    send_pixel(bright);
    configure(FMT_ARGB8, 0, 1, 1);
    send_pixel(bright);
    configure(FMT_ARGB8, 1, 0, 1);
    send_pixel(bright);
    configure(FMT_ARGB8, 1, 1, 0);
    send_pixel(bright);

    while (pixels_fed < 180) random_chain();
    send_idle = 60;
    recv_idle = 8;
    while (pixels_fed < 360) random_chain();
    send_idle = 0;
    recv_idle = 0;
    while (pixels_fed < 540) random_chain();

    // a multi-level chain, run to its end unless run_chain cuts it short at random
    run_chain(FMT_ARGB4, 16, 16, 15, 20000);

    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
